@@ rtl/fcba_pkg.sv @@
package fcba_pkg;

   localparam int FCBA_NUM_BLOCKS      = 256;
   localparam int FCBA_ROOT_ENTRIES    = 16;
   localparam int FCBA_RESERVED_BLOCKS = 7;

   localparam int ACT_W = 3;
   localparam int KEY_W = 64;
   localparam int BIX_W = 8;
   localparam int ST_W  = 3;
   localparam int RES_W = 8;

   localparam logic [ACT_W-1:0] ACT_CREATE = 3'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_APPEND = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_NEXT   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_FIRST  = 3'd5;

   typedef enum logic [ST_W-1:0] {
      ST_OK, ST_NOT_FOUND, ST_EXISTS, ST_DIR_FULL,
      ST_NO_SPACE, ST_NOT_IN_FILE, ST_BAD_BLOCK, ST_NOT_EMPTY
   } status_type;

   // link table read address source
   typedef enum logic [1:0] {RA_ZERO, RA_RDATA, RA_CUR, RA_B} ra_sel_type;
   // link table write address source
   typedef enum logic [2:0] {WA_ZERO, WA_HEAD, WA_CUR, WA_B, WA_PREV} wa_sel_type;
   // link table write data source
   typedef enum logic [2:0] {WD_ZERO, WD_RDATA, WD_HEAD, WD_B, WD_FMT} wd_sel_type;
   // result block source
   typedef enum logic [1:0] {RS_ZERO, RS_HEAD, RS_FIRST, RS_LINK} res_sel_type;

   typedef struct packed {
      logic        fmt_step;
      logic        load_req;
      logic        scan_step;
      logic        dir_create;
      logic        dir_remove;
      logic        dir_set_first;
      logic        first_from_head;
      logic        ld_first;
      logic        ld_head;
      logic        walk_step;
      ra_sel_type  link_ra;
      logic        link_we;
      wa_sel_type  link_wa;
      wd_sel_type  link_wd;
      logic        set_pend;
      status_type  pend_status;
      res_sel_type pend_res;
      logic        ld_out;
   } cmd_type;

   typedef struct packed {
      logic             fmt_last;
      logic             scan_last;
      logic             hit;
      logic             has_free;
      logic             first_zero;
      logic             first_is_b;
      logic             bad_block;
      logic             link_zero;
      logic             cur_zero;
      logic             cur_is_b;
      logic             steps_full;
      logic             steps_last;
      logic [ACT_W-1:0] act;
   } stat_type;

endpackage

@@ rtl/fcba_if.sv @@
interface fcba_req_if import fcba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   logic [KEY_W-1:0] name_key;
   logic [BIX_W-1:0] block_index;

   modport source (output valid, action, name_key, block_index, input ready);
   modport sink   (input valid, action, name_key, block_index, output ready);
endinterface

interface fcba_rsp_if import fcba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ST_W-1:0]  status;
   logic [RES_W-1:0] block_result;

   modport source (output valid, status, block_result, input ready);
   modport sink   (input valid, status, block_result, output ready);
endinterface

@@ rtl/fcba_ctrl.sv @@
module fcba_ctrl import fcba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_FMT, S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_FIRST,
      S_HEAD, S_HEAD_NX, S_HEAD_CLR, S_TAIL, S_TAIL_WR,
      S_CHK, S_WALK, S_BNX, S_FREE, S_FREE_WR, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.link_ra  = RA_ZERO;
      cmd.link_wa  = WA_ZERO;
      cmd.link_wd  = WD_ZERO;
      cmd.pend_status = ST_OK;
      cmd.pend_res = RS_ZERO;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_FMT: begin
            cmd.fmt_step = 1'b1;
            cmd.link_we  = 1'b1;
            cmd.link_wa  = WA_CUR;
            cmd.link_wd  = WD_FMT;
            if (stat.fmt_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            cmd.scan_step = 1'b1;
            state_in = stat.scan_last ? S_DECIDE : S_SCAN_RD;
         end
         S_DECIDE: begin
            priority if (stat.act == ACT_CREATE) begin
               cmd.set_pend = 1'b1;
               state_in     = S_DONE;
               if (stat.hit) cmd.pend_status = ST_EXISTS;
               else if (!stat.has_free) cmd.pend_status = ST_DIR_FULL;
               else cmd.dir_create = 1'b1;
            end else if (stat.act > ACT_FIRST) begin
               cmd.set_pend = 1'b1;
               state_in     = S_DONE;
            end else if (!stat.hit) begin
               cmd.set_pend    = 1'b1;
               cmd.pend_status = ST_NOT_FOUND;
               state_in        = S_DONE;
            end else begin
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            cmd.ld_first = 1'b1;
            priority if (stat.act == ACT_REMOVE) begin
               cmd.set_pend = 1'b1;
               state_in     = S_DONE;
               if (!stat.first_zero) cmd.pend_status = ST_NOT_EMPTY;
               else cmd.dir_remove = 1'b1;
            end else if (stat.act == ACT_FIRST) begin
               cmd.set_pend = 1'b1;
               cmd.pend_res = RS_FIRST;
               state_in     = S_DONE;
            end else if (stat.act == ACT_APPEND) begin
               cmd.link_ra = RA_ZERO;
               state_in    = S_HEAD;
            end else if (stat.bad_block) begin
               cmd.set_pend    = 1'b1;
               cmd.pend_status = ST_BAD_BLOCK;
               state_in        = S_DONE;
            end else begin
               state_in = S_CHK;
            end
         end
         S_HEAD: begin
            cmd.ld_head = 1'b1;
            if (stat.link_zero) begin
               cmd.set_pend    = 1'b1;
               cmd.pend_status = ST_NO_SPACE;
               state_in        = S_DONE;
            end else begin
               cmd.link_ra = RA_RDATA;
               state_in    = S_HEAD_NX;
            end
         end
         S_HEAD_NX: begin
            // free head moves on to the taken block's successor
            cmd.link_we = 1'b1;
            cmd.link_wa = WA_ZERO;
            cmd.link_wd = WD_RDATA;
            state_in    = S_HEAD_CLR;
         end
         S_HEAD_CLR: begin
            cmd.link_we = 1'b1;
            cmd.link_wa = WA_HEAD;
            cmd.link_wd = WD_ZERO;
            if (stat.first_zero) begin
               cmd.dir_set_first   = 1'b1;
               cmd.first_from_head = 1'b1;
               cmd.set_pend        = 1'b1;
               cmd.pend_res        = RS_HEAD;
               state_in            = S_DONE;
            end else begin
               cmd.link_ra = RA_CUR;
               state_in    = S_TAIL;
            end
         end
         S_TAIL: begin
            if (stat.link_zero) begin
               cmd.link_we  = 1'b1;
               cmd.link_wa  = WA_CUR;
               cmd.link_wd  = WD_HEAD;
               cmd.set_pend = 1'b1;
               cmd.pend_res = RS_HEAD;
               state_in     = S_DONE;
            end else begin
               cmd.walk_step = 1'b1;
               cmd.link_ra   = RA_RDATA;
               if (stat.steps_last) state_in = S_TAIL_WR;
            end
         end
         S_TAIL_WR: begin
            cmd.link_we  = 1'b1;
            cmd.link_wa  = WA_CUR;
            cmd.link_wd  = WD_HEAD;
            cmd.set_pend = 1'b1;
            cmd.pend_res = RS_HEAD;
            state_in     = S_DONE;
         end
         S_CHK: begin
            priority if (stat.steps_full || stat.cur_zero) begin
               cmd.set_pend    = 1'b1;
               cmd.pend_status = ST_NOT_IN_FILE;
               state_in        = S_DONE;
            end else if (stat.cur_is_b) begin
               cmd.link_ra = RA_B;
               state_in    = S_BNX;
            end else begin
               cmd.link_ra = RA_CUR;
               state_in    = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            state_in      = S_CHK;
         end
         S_BNX: begin
            if (stat.act == ACT_NEXT) begin
               cmd.set_pend = 1'b1;
               cmd.pend_res = RS_LINK;
               state_in     = S_DONE;
            end else begin
               // unlink from the chain, then push onto the free head
               if (stat.first_is_b) begin
                  cmd.dir_set_first = 1'b1;
               end else begin
                  cmd.link_we = 1'b1;
                  cmd.link_wa = WA_PREV;
                  cmd.link_wd = WD_RDATA;
               end
               cmd.link_ra = RA_ZERO;
               state_in    = S_FREE;
            end
         end
         S_FREE: begin
            cmd.link_we = 1'b1;
            cmd.link_wa = WA_B;
            cmd.link_wd = WD_RDATA;
            state_in    = S_FREE_WR;
         end
         S_FREE_WR: begin
            cmd.link_we  = 1'b1;
            cmd.link_wa  = WA_ZERO;
            cmd.link_wd  = WD_B;
            cmd.set_pend = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.ld_out   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FMT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_req_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_SCAN_RD)
      else $error("accepted request did not start the directory scan");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_format_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FMT && !stat.fmt_last) |=> state_ff == S_FMT)
      else $error("format pass left early");

endmodule

@@ rtl/fcba_dp.sv @@
module fcba_dp import fcba_pkg::*; #(
   parameter int NUM_BLOCKS      = FCBA_NUM_BLOCKS,
   parameter int ROOT_ENTRIES    = FCBA_ROOT_ENTRIES,
   parameter int RESERVED_BLOCKS = FCBA_RESERVED_BLOCKS
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic [ACT_W-1:0] req_action,
   input  logic [KEY_W-1:0] req_name_key,
   input  logic [BIX_W-1:0] req_block_index,
   output logic [ST_W-1:0]  rsp_status,
   output logic [RES_W-1:0] rsp_block_result
);

   localparam int BW    = $clog2(NUM_BLOCKS);
   localparam int SW    = (ROOT_ENTRIES > 1) ? $clog2(ROOT_ENTRIES) : 1;
   localparam int CW    = $clog2(NUM_BLOCKS + 1);
   localparam int START = RESERVED_BLOCKS + 1;

   logic [BW-1:0]    link_mem [NUM_BLOCKS];
   logic [KEY_W-1:0] name_mem [ROOT_ENTRIES];
   logic [BW-1:0]    first_mem [ROOT_ENTRIES];
   logic [ROOT_ENTRIES-1:0] used_ff;

   logic [BW-1:0]    link_rd_ff, first_rd_ff;
   logic [KEY_W-1:0] name_rd_ff, key_ff;
   logic [ACT_W-1:0] act_ff;
   logic [BIX_W-1:0] bix_ff;
   logic [SW-1:0]    idx_ff, slot_ff, free_ff;
   logic             hit_ff, has_free_ff;
   logic [BW-1:0]    cur_ff, prev_ff, head_ff;
   logic [CW-1:0]    steps_ff;
   status_type       pend_status_ff;
   logic [RES_W-1:0] pend_res_ff, out_res_ff;
   logic [ST_W-1:0]  out_status_ff;

   logic [BW+BIX_W-1:0] bext;
   logic [BW-1:0]       b_addr, link_ra, link_wa, link_wd, first_wd;
   logic [SW-1:0]       dir_wa;
   logic [RES_W-1:0]    res_sel;

   function automatic logic [BW-1:0] fmt_link(input logic [BW-1:0] i);
      logic [BW-1:0] v;
      if (i == '0)
         v = (START < NUM_BLOCKS) ? BW'(START) : '0;
      else if (int'(i) <= RESERVED_BLOCKS)
         v = i;
      else if (int'(i) + 1 < NUM_BLOCKS)
         v = i + BW'(1);
      else
         v = '0;
      return v;
   endfunction

   function automatic logic [RES_W-1:0] low_byte(input logic [BW-1:0] v);
      logic [BW+RES_W-1:0] e;
      e = {{RES_W{1'b0}}, v};
      return e[RES_W-1:0];
   endfunction

   assign bext   = {{BW{1'b0}}, bix_ff};
   assign b_addr = bext[BW-1:0];

   always_comb begin
      unique case (cmd.link_ra)
         RA_ZERO:  link_ra = '0;
         RA_RDATA: link_ra = link_rd_ff;
         RA_CUR:   link_ra = cur_ff;
         RA_B:     link_ra = b_addr;
         default:  link_ra = '0;
      endcase
      unique case (cmd.link_wa)
         WA_ZERO: link_wa = '0;
         WA_HEAD: link_wa = head_ff;
         WA_CUR:  link_wa = cur_ff;
         WA_B:    link_wa = b_addr;
         WA_PREV: link_wa = prev_ff;
         default: link_wa = '0;
      endcase
      unique case (cmd.link_wd)
         WD_ZERO:  link_wd = '0;
         WD_RDATA: link_wd = link_rd_ff;
         WD_HEAD:  link_wd = head_ff;
         WD_B:     link_wd = b_addr;
         WD_FMT:   link_wd = fmt_link(cur_ff);
         default:  link_wd = '0;
      endcase
      unique case (cmd.pend_res)
         RS_ZERO:  res_sel = '0;
         RS_HEAD:  res_sel = low_byte(head_ff);
         RS_FIRST: res_sel = low_byte(first_rd_ff);
         RS_LINK:  res_sel = low_byte(link_rd_ff);
         default:  res_sel = '0;
      endcase
   end

   assign first_wd = cmd.first_from_head ? head_ff : link_rd_ff;
   assign dir_wa   = cmd.dir_create ? free_ff : slot_ff;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.link_we) link_mem[link_wa] <= link_wd;
      link_rd_ff <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.dir_create) name_mem[dir_wa] <= key_ff;
      if (cmd.dir_create || cmd.dir_set_first)
         first_mem[dir_wa] <= cmd.dir_create ? '0 : first_wd;
      name_rd_ff  <= name_mem[idx_ff];
      first_rd_ff <= first_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.dir_create) begin
         used_ff[free_ff] <= 1'b1;
      end else if (cmd.dir_remove) begin
         used_ff[slot_ff] <= 1'b0;
      end
   end

   // request, scan and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff      <= req_action;
         key_ff      <= req_name_key;
         bix_ff      <= req_block_index;
         idx_ff      <= '0;
         hit_ff      <= 1'b0;
         has_free_ff <= 1'b0;
      end
      if (cmd.scan_step) begin
         if (used_ff[idx_ff] && name_rd_ff == key_ff && !hit_ff) begin
            hit_ff  <= 1'b1;
            slot_ff <= idx_ff;
         end
         if (!used_ff[idx_ff] && !has_free_ff) begin
            has_free_ff <= 1'b1;
            free_ff     <= idx_ff;
         end
         if (!stat.scan_last) idx_ff <= idx_ff + SW'(1);
      end
      if (cmd.ld_head) head_ff <= link_rd_ff;
      if (cmd.ld_first) begin
         prev_ff  <= '0;
         steps_ff <= '0;
      end else if (cmd.walk_step) begin
         prev_ff  <= cur_ff;
         steps_ff <= steps_ff + CW'(1);
      end
   end

   // cur doubles as the format pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else if (cmd.fmt_step) begin
         cur_ff <= cur_ff + BW'(1);
      end else if (cmd.ld_first) begin
         cur_ff <= first_rd_ff;
      end else if (cmd.walk_step) begin
         cur_ff <= link_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_pend) begin
         pend_status_ff <= cmd.pend_status;
         pend_res_ff    <= (cmd.pend_status == ST_OK) ? res_sel : '0;
      end
      if (cmd.ld_out) begin
         out_status_ff <= pend_status_ff;
         out_res_ff    <= pend_res_ff;
      end
   end

   assign rsp_status       = out_status_ff;
   assign rsp_block_result = out_res_ff;

   always_comb begin
      stat.fmt_last   = (cur_ff == BW'(NUM_BLOCKS - 1));
      stat.scan_last  = (idx_ff == SW'(ROOT_ENTRIES - 1));
      stat.hit        = hit_ff;
      stat.has_free   = has_free_ff;
      stat.first_zero = (first_rd_ff == '0);
      stat.first_is_b = (first_rd_ff == b_addr);
      stat.bad_block  = (bix_ff == '0) || (bext >= (BW+BIX_W)'(NUM_BLOCKS));
      stat.link_zero  = (link_rd_ff == '0);
      stat.cur_zero   = (cur_ff == '0);
      stat.cur_is_b   = (cur_ff == b_addr);
      stat.steps_full = (steps_ff == CW'(NUM_BLOCKS));
      stat.steps_last = (steps_ff == CW'(NUM_BLOCKS - 1));
      stat.act        = act_ff;
   end

endmodule

@@ rtl/fat_chain_block_allocator_core.sv @@
// File allocation table with a small root directory. After reset the block
// runs a format pass over every link table entry that rebuilds the free
// chain and takes no request until it ends. One request is in work at a
// time. Every request scans the directory first, reading and comparing each
// entry, followed by a decision; append walks the file's chain to its tail
// one block per step, delete and next-block walk it through a check and a
// walk state per block. The link table has a single read and write port
// with a registered read, and that port sets the walk speed. A finished
// result sits in an output register while the next request is taken.
module fat_chain_block_allocator_core import fcba_pkg::*; #(
   parameter int NUM_BLOCKS      = FCBA_NUM_BLOCKS,
   parameter int ROOT_ENTRIES    = FCBA_ROOT_ENTRIES,
   parameter int RESERVED_BLOCKS = FCBA_RESERVED_BLOCKS
) (
   input logic        clock,
   input logic        reset,
   fcba_req_if.sink   req_chan,
   fcba_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   fcba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fcba_dp #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .ROOT_ENTRIES    (ROOT_ENTRIES),
      .RESERVED_BLOCKS (RESERVED_BLOCKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_chan.action),
      .req_name_key     (req_chan.name_key),
      .req_block_index  (req_chan.block_index),
      .rsp_status       (rsp_chan.status),
      .rsp_block_result (rsp_chan.block_result)
   );

endmodule

@@ bench/fat_chain_block_allocator_core_test.sv @@
module fat_chain_block_allocator_core_test;
   import fcba_pkg::*;

   localparam int NB = FCBA_NUM_BLOCKS;
   localparam int NE = FCBA_ROOT_ENTRIES;
   localparam int NR = FCBA_RESERVED_BLOCKS;
   localparam int CYCLE_LIMIT = 5000000;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [RES_W-1:0] block_result;
   } alloc_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fcba_req_if req_chan ();
   fcba_rsp_if rsp_chan ();

   fat_chain_block_allocator_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [7:0]       fat_link [NB];
   logic [KEY_W-1:0] slot_name [NE];
   logic             slot_used [NE];
   logic [7:0]       slot_first [NE];

   alloc_rsp_type pending_rsps [$];
   int  mismatches = 0;
   int  unexpected = 0;
   int  rsp_count  = 0;
   int  status_seen [8];
   longint cycles  = 0;
   int  hold_cycles = 0;
   int  stall_pct  = 30;

   // name pool kept small so that lookups hit often
   logic [KEY_W-1:0] name_pool [24];

   function automatic void format_disk();
      for (int i = 0; i < NB; i++) begin
         if (i == 0) fat_link[i] = (NR + 1 < NB) ? 8'(NR + 1) : 8'd0;
         else if (i <= NR) fat_link[i] = 8'(i);
         else if (i + 1 < NB) fat_link[i] = 8'(i + 1);
         else fat_link[i] = 8'd0;
      end
      for (int i = 0; i < NE; i++) begin
         slot_name[i] = '0;
         slot_used[i] = 1'b0;
         slot_first[i] = '0;
      end
   endfunction

   function automatic int lookup_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < NE; i++)
         if (slot_used[i] && slot_name[i] == key) return i;
      return -1;
   endfunction

   function automatic bit chain_holds(logic [7:0] first, logic [7:0] blk);
      logic [7:0] cur;
      cur = first;
      for (int n = 0; n < NB && cur != 0; n++) begin
         if (cur == blk) return 1'b1;
         cur = fat_link[cur];
      end
      return 1'b0;
   endfunction

   function automatic alloc_rsp_type predict_alloc(logic [ACT_W-1:0] act,
                                                   logic [KEY_W-1:0] key,
                                                   logic [7:0] blk);
      alloc_rsp_type r;
      int s;
      logic [7:0] head, cur, nx;
      r.status = ST_OK;
      r.block_result = '0;
      if (act == ACT_CREATE) begin
         if (lookup_slot(key) >= 0) r.status = ST_EXISTS;
         else begin
            r.status = ST_DIR_FULL;
            for (int i = 0; i < NE; i++)
               if (!slot_used[i]) begin
                  slot_used[i] = 1'b1;
                  slot_name[i] = key;
                  slot_first[i] = '0;
                  r.status = ST_OK;
                  break;
               end
         end
      end else if (act >= ACT_REMOVE && act <= ACT_FIRST) begin
         s = lookup_slot(key);
         if (s < 0) r.status = ST_NOT_FOUND;
         else if (act == ACT_REMOVE) begin
            if (slot_first[s] != 0) r.status = ST_NOT_EMPTY;
            else begin
               slot_used[s] = 1'b0;
               slot_name[s] = '0;
            end
         end else if (act == ACT_APPEND) begin
            head = fat_link[0];
            if (head == 0) r.status = ST_NO_SPACE;
            else begin
               fat_link[0] = fat_link[head];
               fat_link[head] = '0;
               if (slot_first[s] == 0) slot_first[s] = head;
               else begin
                  cur = slot_first[s];
                  for (int n = 0; n < NB; n++) begin
                     nx = fat_link[cur];
                     if (nx == 0) break;
                     cur = nx;
                  end
                  fat_link[cur] = head;
               end
               r.block_result = head;
            end
         end else if (act == ACT_DELETE || act == ACT_NEXT) begin
            if (blk == 0) r.status = ST_BAD_BLOCK;
            else if (!chain_holds(slot_first[s], blk)) r.status = ST_NOT_IN_FILE;
            else if (act == ACT_NEXT) r.block_result = fat_link[blk];
            else begin
               if (slot_first[s] == blk) slot_first[s] = fat_link[blk];
               else begin
                  cur = slot_first[s];
                  for (int n = 0; n < NB; n++) begin
                     nx = fat_link[cur];
                     if (nx == blk || nx == 0) break;
                     cur = nx;
                  end
                  if (fat_link[cur] == blk) fat_link[cur] = fat_link[blk];
               end
               fat_link[blk] = fat_link[0];
               fat_link[0] = blk;
            end
         end else r.block_result = slot_first[s];
      end
      return r;
   endfunction

   initial begin
      req_chan.valid = 1'b0;
      req_chan.action = '0;
      req_chan.name_key = '0;
      req_chan.block_index = '0;
      rsp_chan.ready = 1'b0;
   end

   task automatic send_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                               logic [7:0] blk);
      req_chan.valid <= 1'b1;
      req_chan.action <= act;
      req_chan.name_key <= key;
      req_chan.block_index <= blk;
      do @(posedge clock); while (!req_chan.ready);
      pending_rsps.insert(pending_rsps.size(), predict_alloc(act, key, blk));
   endtask

   // bursts: keep valid high through a burst, drop it in gaps
   int burst_left = 0;
   task automatic issue(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                        logic [7:0] blk);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_request(act, key, blk);
   endtask

   task automatic go_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      go_idle();
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // receiver stall pattern; a long hold counts down here
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_chan.ready <= 1'b0;
      end else rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      alloc_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_count++;
         status_seen[rsp_chan.status]++;
         if (pending_rsps.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("unexpected transfer: status %0d block %0d",
                        rsp_chan.status, rsp_chan.block_result);
         end else begin
            want = pending_rsps.pop_front();
            if (want.status != rsp_chan.status
                || want.block_result != rsp_chan.block_result) begin
               mismatches++;
               if (mismatches + unexpected <= 10)
                  $display("mismatch: expected status %0d block %0d, got %0d %0d",
                           want.status, want.block_result,
                           rsp_chan.status, rsp_chan.block_result);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d transfers pending", pending_rsps.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [KEY_W-1:0] pick_name();
      return name_pool[$urandom_range(0, 23)];
   endfunction

   function automatic logic [7:0] pick_block();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'($urandom_range(1, NR));
         2, 3: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(NR + 1, NR + 40));
      endcase
   endfunction

   task automatic test_directed();
      send_request(ACT_FIRST, 64'd0, 8'd0);
      send_request(ACT_CREATE, 64'd0, 8'd0);
      send_request(ACT_CREATE, 64'd0, 8'd0);
      send_request(ACT_CREATE, '1, 8'hFF);
      send_request(ACT_APPEND, '1, 8'd0);
      send_request(ACT_APPEND, '1, 8'd0);
      send_request(ACT_APPEND, '1, 8'd0);
      send_request(ACT_NEXT, '1, 8'd0);
      send_request(ACT_NEXT, '1, 8'hFF);
      send_request(ACT_NEXT, '1, 8'd8);
      send_request(ACT_NEXT, '1, 8'd3);
      send_request(ACT_FIRST, '1, 8'd0);
      send_request(ACT_REMOVE, '1, 8'd0);
      send_request(ACT_DELETE, '1, 8'd9);
      send_request(ACT_DELETE, '1, 8'd8);
      send_request(ACT_DELETE, '1, 8'd10);
      send_request(ACT_REMOVE, '1, 8'd0);
      send_request(ACT_REMOVE, 64'h55, 8'd0);
      send_request(ACT_APPEND, 64'h55, 8'd0);
      send_request(ACT_DELETE, 64'h55, 8'd9);
      send_request(3'd6, 64'd0, 8'd1);
      send_request(3'd7, '1, 8'hAA);
      drain();
   endtask

   task automatic test_dir_full();
      for (int i = 0; i <= NE; i++)
         issue(ACT_CREATE, 64'h4600 + i, 8'd0);
      for (int i = 0; i < NE; i++)
         issue(ACT_REMOVE, (i == 0) ? 64'd0 : 64'h4600 + i, 8'd0);
      drain();
   endtask

   // one file takes every free block, then hands them back
   task automatic test_no_space();
      issue(ACT_CREATE, 64'h424947, 8'd0);
      for (int i = 0; i < NB - NR; i++)
         issue(ACT_APPEND, 64'h424947, 8'd0);
      issue(ACT_NEXT, 64'h424947, 8'($urandom_range(NR + 1, NB - 1)));
      for (int i = 0; i < NB - NR - 1; i++)
         issue(ACT_DELETE, 64'h424947,
               (i % 2) ? 8'(NR + 1 + i) : 8'(NB - 1 - i / 2));
      for (int b = NR + 1; b < NB; b++)
         issue(ACT_DELETE, 64'h424947, 8'(b));
      issue(ACT_REMOVE, 64'h424947, 8'd0);
      drain();
   endtask

   // receiver holds off while the sender keeps offering requests
   task automatic test_backpressure();
      hold_cycles = 400;
      for (int i = 0; i < 6; i++)
         send_request(ACT_CREATE, name_pool[i], 8'd0);
      drain();
   endtask

   task automatic test_random(int count);
      logic [ACT_W-1:0] act;
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 12) act = ACT_CREATE;
         else if (r < 20) act = ACT_REMOVE;
         else if (r < 48) act = ACT_APPEND;
         else if (r < 68) act = ACT_DELETE;
         else if (r < 88) act = ACT_NEXT;
         else if (r < 97) act = ACT_FIRST;
         else act = 3'($urandom_range(6, 7));
         if (n % 400 == 200) stall_pct = (stall_pct == 0) ? 60 : 0;
         issue(act, ($urandom_range(0, 19) == 0)
                    ? {$urandom, $urandom} : pick_name(), pick_block());
         if (n % 300 == 299) drain();
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < 24; i++)
         name_pool[i] = (i < 2) ? (i ? '1 : 64'd0) : {$urandom, $urandom};
      format_disk();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_dir_full();
      test_backpressure();
      test_no_space();
      test_random(850);
      drain();
      repeat (600) @(posedge clock);
      $display("covered %0d responses: ok %0d, not found %0d, exists %0d, dir full %0d",
               rsp_count, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      $display("  no space %0d, not in file %0d, bad block %0d, not empty %0d",
               status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
      if (mismatches == 0 && unexpected == 0 && pending_rsps.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
